// ----- hw/rtl/cms_pkg.sv -----
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types, sizes and helpers for the count-min sketch block.
// ----------------------------------------------------------------------------
package cms_pkg;

  localparam int ROWS        = 4;
  localparam int COLUMNS     = 1024;
  localparam int HASH_WORDS  = 4;
  localparam int HASH_W      = 32;
  localparam int CNT_W       = 32;
  localparam int TOTAL_W     = 64;
  localparam int CFG_W       = 11;
  localparam int COL_W       = $clog2(COLUMNS);
  localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ADDR_W      = ROW_W + COL_W;
  localparam int MEM_DEPTH   = 1 << ADDR_W;
  localparam int REQ_W       = 2;
  localparam int IN_DATA_W   = HASH_W * (HASH_WORDS + 1);
  localparam int OUT_DATA_W  = CNT_W + TOTAL_W;

  // modulo unit: MOD_BITS quotient bits per cycle
  localparam int MOD_BITS    = 8;
  localparam int MOD_STEPS   = HASH_W / MOD_BITS;
  localparam int STEP_W      = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  typedef logic [ROWS-1:0][HASH_W-1:0] hash_arr_t;
  typedef logic [ROWS-1:0][COL_W-1:0]  col_arr_t;

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE   = 2'd0,
    REQ_ESTIMATE = 2'd1,
    REQ_CLEAR    = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_ACCESS,
    ST_SWEEP,
    ST_DONE
  } state_t;

  // Fold MOD_BITS more dividend bits into a partial remainder.
  // The remainder stays below cols, so the shifted value fits in CFG_W bits.
  function automatic logic [COL_W-1:0] mod_step(input logic [COL_W-1:0]    rem,
                                                input logic [MOD_BITS-1:0] bits,
                                                input logic [CFG_W-1:0]    cols);
    logic [CFG_W-1:0] acc;
    acc = {1'b0, rem};
    for (int i = MOD_BITS - 1; i >= 0; i--) begin
      acc = {acc[COL_W-1:0], bits[i]};
      if (acc >= cols) begin
        acc = acc - cols;
      end
    end
    return acc[COL_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/cms_mod_unit.sv -----
// ----------------------------------------------------------------------------
// cms_mod_unit
// Column select: one lane per row reduces its hash word modulo the column
// count, MOD_BITS dividend bits per cycle.
// ----------------------------------------------------------------------------
module cms_mod_unit
  import cms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  hash_arr_t        words,
  input  logic [CFG_W-1:0] cols,
  output logic             done,
  output col_arr_t         col
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [CFG_W-1:0]      cols_r;
  hash_arr_t             div_r;
  col_arr_t              rem_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r) begin
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // lanes: take the top bits of each dividend, shift the rest up
  always_ff @(posedge clk) begin
    if (start) begin
      cols_r <= cols;
      div_r  <= words;
      rem_r  <= '0;
    end else if (busy_r) begin
      for (int r = 0; r < ROWS; r++) begin
        rem_r[r] <= mod_step(rem_r[r], div_r[r][HASH_W-1 -: MOD_BITS], cols_r);
        div_r[r] <= {div_r[r][HASH_W-MOD_BITS-1:0], {MOD_BITS{1'b0}}};
      end
    end
  end

  assign done = done_r;
  assign col  = rem_r;

endmodule

// ----- hw/rtl/count_min_sketch.sv -----
// ----------------------------------------------------------------------------
// count_min_sketch
// Count-min sketch: ROWS rows of 32-bit counters in one counter memory.
// ----------------------------------------------------------------------------
// Requests enter on the in_ stream: in_tuser carries the request kind
// (update, estimate, clear), in_tdata one hash word per row and the add
// amount. Each request yields exactly one result on the out_ stream with
// the estimate (zero unless an estimate request) and the 64-bit running
// total. active_columns must be written through cfg_wr_en / cfg_wr_data
// only while the block is idle; the block itself does not enforce this.
// 0 acts as 1, values above COLUMNS act as COLUMNS. One request is worked
// at a time. Update and estimate run the column modulo unit (8 bits per
// cycle), then one read per row on the counter memory, whose single read
// port walks the rows in turn; an update also writes each row back. A new
// request is taken in the same cycle that the result reaches the output
// register. A clear sweeps all 4096 entries, one per cycle, and its result
// follows the sweep. After reset the same full sweep zeroes the memory;
// in_tready stays low until it ends. The result sits in an output register,
// so the next request is taken while it waits; a request that finishes
// while the receiver still stalls holds until the register frees.
// ----------------------------------------------------------------------------
module count_min_sketch
  import cms_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_W-1:0]      cfg_wr_data,   // active_columns
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,      // hash_word_0..3, add_amount
  input  logic [REQ_W-1:0]      in_tuser,      // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata      // estimate, running_total
);

  state_t               state_r, state_nxt;
  req_t                 req_r, req_nxt;
  logic                 has_item_r, has_item_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]     cfg_cols_r;
  logic [TOTAL_W-1:0]   total_r, total_nxt;
  logic [ROW_W:0]       issue_cnt_r, issue_cnt_nxt;
  logic                 rd_vld_r, rd_vld_nxt;
  logic [ROW_W-1:0]     rd_row_r, rd_row_nxt;
  logic [ADDR_W-1:0]    sweep_cnt_r, sweep_cnt_nxt;
  logic [CNT_W-1:0]     amount_r, amount_nxt;
  logic [CNT_W-1:0]     min_r, min_nxt;
  logic [CNT_W-1:0]     out_est_r;
  logic [TOTAL_W-1:0]   out_total_r;
  logic                 out_load;

  logic [CFG_W-1:0]     eff_cols;
  logic                 mod_start;
  logic                 mod_done;
  col_arr_t             col;
  hash_arr_t            words;
  logic [CNT_W-1:0]     in_amount;
  logic [ROW_W-1:0]     issue_row;

  logic [CNT_W-1:0]     cnt_mem [MEM_DEPTH];
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [CNT_W-1:0]     mem_wdata;
  logic [ADDR_W-1:0]    mem_raddr;
  logic [CNT_W-1:0]     mem_rdata_r;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      words[r] = in_tdata[r*HASH_W +: HASH_W];
    end
  end
  assign in_amount = in_tdata[HASH_WORDS*HASH_W +: CNT_W];
  assign issue_row = issue_cnt_r[ROW_W-1:0];

  // saturate the column count into 1..COLUMNS
  always_comb begin
    if (cfg_cols_r == '0) begin
      eff_cols = CFG_W'(1);
    end else if (cfg_cols_r > CFG_W'(COLUMNS)) begin
      eff_cols = CFG_W'(COLUMNS);
    end else begin
      eff_cols = cfg_cols_r;
    end
  end

  cms_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .words (words),
    .cols  (eff_cols),
    .done  (mod_done),
    .col   (col)
  );

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    has_item_nxt  = has_item_r;
    total_nxt     = total_r;
    issue_cnt_nxt = issue_cnt_r;
    rd_vld_nxt    = 1'b0;
    rd_row_nxt    = rd_row_r;
    sweep_cnt_nxt = sweep_cnt_r;
    amount_nxt    = amount_r;
    min_nxt       = min_r;
    in_tready     = 1'b0;
    mod_start     = 1'b0;
    out_load      = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          req_nxt      = req_t'(in_tuser);
          amount_nxt   = in_amount;
          min_nxt      = '1;
          has_item_nxt = 1'b1;
          case (in_tuser)
            REQ_UPDATE: begin
              total_nxt = total_r + TOTAL_W'(in_amount);
              mod_start = 1'b1;
              state_nxt = ST_MOD;
            end
            REQ_ESTIMATE: begin
              mod_start = 1'b1;
              state_nxt = ST_MOD;
            end
            REQ_CLEAR: begin
              sweep_cnt_nxt = '0;
              state_nxt     = ST_SWEEP;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_MOD: begin
        if (mod_done) begin
          issue_cnt_nxt = '0;
          state_nxt     = ST_ACCESS;
        end
      end

      ST_ACCESS: begin
        // issue one row read per cycle, process the returning data in the next cycle
        if (issue_cnt_r < (ROW_W+1)'(ROWS)) begin
          mem_raddr     = {issue_row, col[issue_row]};
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          rd_vld_nxt    = 1'b1;
          rd_row_nxt    = issue_row;
        end
        if (rd_vld_r) begin
          if (req_r == REQ_UPDATE) begin
            mem_we    = 1'b1;
            mem_waddr = {rd_row_r, col[rd_row_r]};
            mem_wdata = mem_rdata_r + amount_r;
          end else if (mem_rdata_r < min_r) begin
            min_nxt = mem_rdata_r;
          end
          if (rd_row_r == ROW_W'(ROWS - 1)) begin
            state_nxt = ST_DONE;
          end
        end
      end

      ST_SWEEP: begin
        mem_we        = 1'b1;
        mem_waddr     = sweep_cnt_r;
        mem_wdata     = '0;
        sweep_cnt_nxt = sweep_cnt_r + 1'b1;
        if (sweep_cnt_r == ADDR_W'(MEM_DEPTH - 1)) begin
          state_nxt = has_item_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_DONE: begin
        // hold until the output register frees
        if (!out_valid_r || out_tready) begin
          out_load     = 1'b1;
          has_item_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      req_r       <= REQ_UPDATE;
      has_item_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_cols_r  <= CFG_W'(COLUMNS);
      total_r     <= '0;
      issue_cnt_r <= '0;
      rd_vld_r    <= 1'b0;
      rd_row_r    <= '0;
      sweep_cnt_r <= '0;
    end else begin
      state_r     <= state_nxt;
      req_r       <= req_nxt;
      has_item_r  <= has_item_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_cols_r <= cfg_wr_data;
      end
      total_r     <= total_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_row_r    <= rd_row_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    amount_r <= amount_nxt;
    min_r    <= min_nxt;
    if (out_load) begin
      out_est_r   <= (req_r == REQ_ESTIMATE) ? min_r : '0;
      out_total_r <= total_r;
    end
  end

  // counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= cnt_mem[mem_raddr];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_est_r};

endmodule
